// ----- rtl/core/ppmfd_pkg.sv -----
// Package for the PPM frame decoder: widths, reset values, register indexes
// and the structures shared between the decoder modules and interfaces.
// Depends on nothing.
`default_nettype none

package ppmfd_pkg;

  localparam int CHANNELS   = 6;
  localparam int TS_W       = 32;
  localparam int WIDTH_W    = 16;
  localparam int CH_IDX_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0]  SYNC_GAP_RST     = WIDTH_W'(5000);
  localparam logic [WIDTH_W-1:0]  STOP_LIMIT_RST   = WIDTH_W'(1100);
  localparam logic [CH_IDX_W-1:0] STOP_CHANNEL_RST = CH_IDX_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_GAP     = 2'd0,
    REG_STOP_LIMIT   = 2'd1,
    REG_STOP_CHANNEL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  sync_gap_us;
    logic [WIDTH_W-1:0]  stop_limit_us;
    logic [CH_IDX_W-1:0] stop_channel;
  } cfg_t;

  typedef struct packed {
    logic            pin_level;
    logic [TS_W-1:0] timestamp_us;
  } edge_t;

  typedef struct packed {
    logic                channel_valid;
    logic [CH_IDX_W-1:0] channel_index;
    logic [WIDTH_W-1:0]  pulse_width_us;
    logic                sync_found;
    logic                frame_done;
    logic                drive_enable;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppmfd_if.sv -----
// Valid/ready channel interfaces for edge events and decoded results.
// Depends on ppmfd_pkg for the field widths.
`default_nettype none

interface ppmfd_edge_if;
  import ppmfd_pkg::*;

  logic            valid;
  logic            ready;
  logic            pin_level;
  logic [TS_W-1:0] timestamp_us;

  modport source (output valid, output pin_level, output timestamp_us, input ready);
  modport sink   (input valid, input pin_level, input timestamp_us, output ready);
endinterface

interface ppmfd_result_if;
  import ppmfd_pkg::*;

  logic                valid;
  logic                ready;
  logic                channel_valid;
  logic [CH_IDX_W-1:0] channel_index;
  logic [WIDTH_W-1:0]  pulse_width_us;
  logic                sync_found;
  logic                frame_done;
  logic                drive_enable;

  modport source (
    output valid, output channel_valid, output channel_index, output pulse_width_us,
    output sync_found, output frame_done, output drive_enable, input ready
  );
  modport sink (
    input valid, input channel_valid, input channel_index, input pulse_width_us,
    input sync_found, input frame_done, input drive_enable, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/ppmfd_decode.sv -----
// Frame state and per-edge decode: rise time, frame and channel tracking and
// the servo enable flag. Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_decode (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      step,
  input  wire ppmfd_pkg::edge_t    item,
  input  wire ppmfd_pkg::cfg_t     cfg,
  output ppmfd_pkg::result_t       res
);
  import ppmfd_pkg::*;

  localparam logic [CH_IDX_W:0] LAST_CMP = (CH_IDX_W+1)'(CHANNELS);

  logic [WIDTH_W-1:0]  rise_lo_r, rise_lo_nxt;
  logic                in_frame_r, in_frame_nxt;
  logic [CH_IDX_W-1:0] count_r, count_nxt;
  logic                enable_r, enable_nxt;

  logic [WIDTH_W-1:0]  width;
  logic [CH_IDX_W:0]   next_count;
  logic                store;
  logic                last;
  logic                sync;

  always_comb begin
    width      = item.timestamp_us[WIDTH_W-1:0] - rise_lo_r;
    next_count = {1'b0, count_r} + (CH_IDX_W+1)'(1);
    store      = !item.pin_level && in_frame_r;
    last       = next_count >= LAST_CMP;
    sync       = !item.pin_level && !in_frame_r && (width > cfg.sync_gap_us);

    rise_lo_nxt  = item.pin_level ? item.timestamp_us[WIDTH_W-1:0] : rise_lo_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    enable_nxt   = enable_r;
    if (store) begin
      count_nxt = next_count[CH_IDX_W-1:0];
      if (last) begin
        in_frame_nxt = 1'b0;
      end
      if (count_r == cfg.stop_channel) begin
        enable_nxt = !(width > cfg.stop_limit_us);
      end
    end else if (sync) begin
      in_frame_nxt = 1'b1;
      count_nxt    = '0;
    end

    res.channel_valid  = store;
    res.channel_index  = store ? count_r : '0;
    res.pulse_width_us = item.pin_level ? '0 : width;
    res.sync_found     = sync;
    res.frame_done     = store && last;
    res.drive_enable   = enable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_lo_r  <= '0;
      in_frame_r <= 1'b0;
      count_r    <= '0;
      enable_r   <= 1'b0;
    end else if (step) begin
      rise_lo_r  <= rise_lo_nxt;
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      enable_r   <= enable_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_frame_decoder.sv -----
// Top level of the PPM frame decoder: input register, decode, result register
// and configuration registers. Depends on ppmfd_pkg, ppmfd_if and ppmfd_decode.
//
// Each transfer on in_ch is one edge of the PPM pin: the level after the edge
// and a free-running microsecond timestamp. Every edge gives exactly one
// result on out_ch, in order: the measured high width on a falling edge, the
// channel index when a channel value was taken, the frame start and frame end
// flags and the current servo enable flag.
// A result passes through the input register and then the result register
// before it is presented. Edges are taken one per cycle without a gap, with
// one item held in the input register and one in the result register; the only limit on rate is the receiver.
// When out_ch stalls, the result register holds its item and the input
// register fills, after which in_ch.ready goes low until the result is taken.
// The cfg port writes sync gap, stop limit and stop channel; the user must write
// it only while no edge is in flight, and the block itself does not enforce this.
// Synchronous reset clears the valid flags of both registers, the frame state, the rise time and
// the enable flag, and loads the configuration reset values.
`default_nettype none

module ppm_frame_decoder (
  input  wire                              clk,
  input  wire                              rst_n,
  ppmfd_edge_if.sink                       in_ch,
  ppmfd_result_if.source                   out_ch,
  input  wire                              cfg_we,
  input  wire [ppmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ppmfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ppmfd_pkg::*;

  cfg_t    cfg_r;
  logic    s1_vld_r;
  edge_t   s1_item_r;
  logic    out_vld_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    s1_move;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign s1_move      = s1_vld_r && out_free;
  assign in_ch.ready  = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_gap_us   <= SYNC_GAP_RST;
      cfg_r.stop_limit_us <= STOP_LIMIT_RST;
      cfg_r.stop_channel  <= STOP_CHANNEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SYNC_GAP:     cfg_r.sync_gap_us   <= cfg_wdata[WIDTH_W-1:0];
        REG_STOP_LIMIT:   cfg_r.stop_limit_us <= cfg_wdata[WIDTH_W-1:0];
        REG_STOP_CHANNEL: cfg_r.stop_channel  <= cfg_wdata[CH_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.pin_level    <= in_ch.pin_level;
      s1_item_r.timestamp_us <= in_ch.timestamp_us;
    end
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  ppmfd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_ch.valid          = out_vld_r;
  assign out_ch.channel_valid  = out_res_r.channel_valid;
  assign out_ch.channel_index  = out_res_r.channel_index;
  assign out_ch.pulse_width_us = out_res_r.pulse_width_us;
  assign out_ch.sync_found     = out_res_r.sync_found;
  assign out_ch.frame_done     = out_res_r.frame_done;
  assign out_ch.drive_enable   = out_res_r.drive_enable;

endmodule

`default_nettype wire

// ----- rtl/core/ppmfd_checker.sv -----
// Port-level assertions for the PPM frame decoder, attached to the top level
// by the bind statement at the end. Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire                             out_channel_valid,
  input wire [ppmfd_pkg::CH_IDX_W-1:0]   out_channel_index,
  input wire [ppmfd_pkg::WIDTH_W-1:0]    out_pulse_width_us,
  input wire                             out_sync_found,
  input wire                             out_frame_done,
  input wire                             out_drive_enable
);
  import ppmfd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an edge transferred two cycles earlier");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sync_found |-> !out_channel_valid && !out_frame_done)
    else $error("frame start reported together with a channel value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_valid)
      && $stable(out_channel_index) && $stable(out_pulse_width_us)
      && $stable(out_sync_found) && $stable(out_frame_done)
      && $stable(out_drive_enable))
    else $error("stalled result changed");

endmodule

bind ppm_frame_decoder ppmfd_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_channel_valid  (out_ch.channel_valid),
  .out_channel_index  (out_ch.channel_index),
  .out_pulse_width_us (out_ch.pulse_width_us),
  .out_sync_found     (out_ch.sync_found),
  .out_frame_done     (out_ch.frame_done),
  .out_drive_enable   (out_ch.drive_enable)
);

`default_nettype wire

// ----- dv/ppm_frame_decoder_test.sv -----
// Self-checking testbench for the PPM frame decoder: edge events go in and
// each decoded result is checked against a predictor of the frame logic.
// Depends on ppmfd_pkg, the ppmfd_if interfaces and the ppm_frame_decoder RTL.
`default_nettype none

module ppm_frame_decoder_test;
  import ppmfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ppmfd_edge_if   in_if ();
  ppmfd_result_if out_if ();

  ppm_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the configuration and the decoder state.
  logic [WIDTH_W-1:0]  sync_gap_m;
  logic [WIDTH_W-1:0]  stop_limit_m;
  logic [CH_IDX_W-1:0] stop_channel_m;
  logic [TS_W-1:0]     rise_time_m;
  logic                in_frame_m;
  logic [CH_IDX_W-1:0] count_m;
  logic                enable_m;

  edge_t   edges_to_send [$];
  result_t decodes_due [$];

  logic [TS_W-1:0] ts_now;
  logic edge_taken;
  logic idle_on;
  int   send_gap;
  int   stall_left;
  int   cycles;
  int   n_queued;
  int   edges_sent;
  int   decodes_checked;
  int   err_count;
  int   frames_opened;
  int   channels_taken;
  int   stops_seen;

  function automatic result_t decode_edge(edge_t ev);
    result_t r;
    logic [CH_IDX_W-1:0] slot;
    logic [CH_IDX_W:0]   next;
    logic [TS_W-1:0]     diff;
    r = '0;
    if (ev.pin_level) begin
      rise_time_m = ev.timestamp_us;
    end else begin
      diff = ev.timestamp_us - rise_time_m;
      r.pulse_width_us = diff[WIDTH_W-1:0];
      if (in_frame_m) begin
        slot = count_m;
        next = {1'b0, slot} + 1'b1;
        r.channel_valid = 1'b1;
        r.channel_index = slot;
        if (slot == stop_channel_m) begin
          enable_m = !(r.pulse_width_us > stop_limit_m);
        end
        if (next >= CHANNELS) begin
          in_frame_m   = 1'b0;
          r.frame_done = 1'b1;
        end
        count_m = next[CH_IDX_W-1:0];
      end else if (r.pulse_width_us > sync_gap_m) begin
        in_frame_m   = 1'b1;
        count_m      = '0;
        r.sync_found = 1'b1;
      end
    end
    r.drive_enable = enable_m;
    return r;
  endfunction

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, decodes_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Edge driver: holds an item until its transfer, with random gaps between items while idle_on is set.
  always @(negedge clk) begin
    edge_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || edge_taken) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (edges_to_send.size() != 0) begin
        nxt = edges_to_send.pop_front();
        in_if.valid        <= 1'b1;
        in_if.pin_level    <= nxt.pin_level;
        in_if.timestamp_us <= nxt.timestamp_us;
        if (idle_on && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 11);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    edge_t   ev;
    edge_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.channel_valid, out_if.channel_index, out_if.pulse_width_us,
               out_if.sync_found, out_if.frame_done, out_if.drive_enable};
        if (decodes_due.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Result transfer with nothing outstanding: %p", got);
          end
        end else begin
          want = decodes_due.pop_front();
          decodes_checked++;
          if (want.sync_found) frames_opened++;
          if (want.channel_valid) channels_taken++;
          if (want.channel_valid && !want.drive_enable &&
              want.channel_index == stop_channel_m) stops_seen++;
          if (got.channel_valid !== want.channel_valid ||
              got.channel_index !== want.channel_index ||
              got.pulse_width_us !== want.pulse_width_us ||
              got.sync_found !== want.sync_found ||
              got.frame_done !== want.frame_done ||
              got.drive_enable !== want.drive_enable) begin
            err_count++;
            if (err_count <= 10) begin
              $display("Mismatch on result %0d: expected %p, got %p",
                       decodes_checked, want, got);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        ev = {in_if.pin_level, in_if.timestamp_us};
        decodes_due.push_back(decode_edge(ev));
        edges_sent++;
      end
    end
  end

  task automatic add_edge(input logic lvl, input logic [TS_W-1:0] ts);
    edge_t e;
    e.pin_level    = lvl;
    e.timestamp_us = ts;
    edges_to_send.push_back(e);
    n_queued++;
  endtask

  task automatic add_pulse(input logic [TS_W-1:0] low_us, input logic [TS_W-1:0] high_us);
    ts_now = ts_now + low_us;
    add_edge(1'b1, ts_now);
    ts_now = ts_now + high_us;
    add_edge(1'b0, ts_now);
  endtask

  function automatic logic [TS_W-1:0] channel_width();
    case ($urandom_range(0, 9))
      0: return {16'd0, stop_limit_m};
      1: return {16'd0, stop_limit_m} + 32'd1;
      2: return $urandom_range(0, 65535);
      3: return $urandom;
      4: return 32'd0;
      5: return 32'd65535;
      default: return $urandom_range(900, 2100);
    endcase
  endfunction

  function automatic logic [TS_W-1:0] sync_width();
    if (sync_gap_m == 16'hFFFF) return $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: return {16'd0, sync_gap_m} + 32'd1;
      1: return 32'd65535;
      default: return $urandom_range(sync_gap_m + 1, 65535);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SYNC_GAP:     sync_gap_m = data;
      REG_STOP_LIMIT:   stop_limit_m = data;
      REG_STOP_CHANNEL: stop_channel_m = data[CH_IDX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The stimulus waits here until every queued edge has been sent and every outstanding result has been taken.
  task automatic wait_idle();
    while (edges_to_send.size() != 0 || in_if.valid || decodes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    int start;
    int k;
    start = n_queued;
    while (n_queued - start < n) begin
      case ($urandom_range(0, 9))
        7: begin
          add_pulse($urandom_range(200, 3000), sync_width());
          k = $urandom_range(0, CHANNELS - 1);
          repeat (k) add_pulse($urandom_range(200, 600), channel_width());
        end
        8: begin
          repeat ($urandom_range(1, 6)) add_edge(1'($urandom_range(0, 1)), $urandom);
        end
        9: add_pulse($urandom_range(1, 600), $urandom);
        default: begin
          add_pulse($urandom_range(200, 3000), sync_width());
          for (int i = 0; i < CHANNELS; i++) begin
            add_pulse($urandom_range(200, 600), channel_width());
          end
        end
      endcase
    end
    wait_idle();
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.pin_level    = 1'b0;
    in_if.timestamp_us = '0;
    out_if.ready       = 1'b0;
    sync_gap_m         = SYNC_GAP_RST;
    stop_limit_m       = STOP_LIMIT_RST;
    stop_channel_m     = STOP_CHANNEL_RST;
    rise_time_m        = '0;
    in_frame_m         = 1'b0;
    count_m            = '0;
    enable_m           = 1'b0;
    idle_on            = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A falling edge straight after reset measures from a rise time of zero.
    ts_now = 32'd5120;
    add_edge(1'b0, ts_now);
    add_pulse(300, 0);
    add_pulse(300, 6000);
    add_pulse(300, 32'h0001_0005);
    add_pulse(300, 65535);
    add_pulse(300, 1100);
    add_pulse(300, 1500);
    add_pulse(300, 5000);
    add_edge(1'b0, ts_now + 32'd40);
    add_edge(1'b1, 32'hFFFF_FF00);
    add_edge(1'b1, 32'hFFFF_FFFF);
    ts_now = 32'h0000_1F00;
    add_edge(1'b0, ts_now);
    wait_idle();

    ts_now = $urandom;
    random_phase(180);

    write_reg(REG_SYNC_GAP, 16'h0000);
    write_reg(REG_STOP_LIMIT, 16'h0000);
    write_reg(REG_STOP_CHANNEL, CFG_DATA_W'(CHANNELS - 1));
    random_phase(180);

    write_reg(REG_SYNC_GAP, 16'hFFFF);
    write_reg(REG_STOP_LIMIT, 16'hFFFF);
    write_reg(REG_STOP_CHANNEL, 16'h000F);
    random_phase(120);

    write_reg(REG_SYNC_GAP, 16'd3000);
    write_reg(REG_STOP_LIMIT, 16'd1500);
    write_reg(REG_STOP_CHANNEL, 16'd0);
    random_phase(180);

    write_reg(REG_SYNC_GAP, CFG_DATA_W'($urandom_range(1000, 20000)));
    write_reg(REG_STOP_LIMIT, CFG_DATA_W'($urandom_range(900, 2100)));
    write_reg(REG_STOP_CHANNEL, 16'd7);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
    random_phase(180);

    idle_on = 1'b0;
    write_reg(REG_SYNC_GAP, SYNC_GAP_RST);
    write_reg(REG_STOP_LIMIT, STOP_LIMIT_RST);
    write_reg(REG_STOP_CHANNEL, CFG_DATA_W'($urandom_range(0, CHANNELS - 1)));
    random_phase(180);

    $display("Drove %0d edges through six register settings and checked %0d results.",
             edges_sent, decodes_checked);
    $display("Frames opened: %0d, channels decoded: %0d, emergency stops: %0d.",
             frames_opened, channels_taken, stops_seen);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total.", err_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
